>>> rtl/rla_pkg.sv
// ============================================================================
// rla_pkg: shared constants for the RGB to log l-alpha-beta converter
// Holds the Q16 cone matrix, the log2 segment table and the output scales.
// ============================================================================
package rla_pkg;

    // Widths of the pixel fields and of the result fields.
    localparam int CODE_W  = 8;
    localparam int LIGHT_W = 17;
    localparam int CHROMA_W = 16;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 56;

    // Cone response sum and its normalized mantissa.
    localparam int RESP_W = 24;
    localparam int EXP_W  = 5;
    localparam int MANT_W = 23;

    // Log2 values in Q16 and the log relative to full scale.
    localparam int LOG_W  = 17;
    localparam int DIFF_W = 13;
    localparam int REL_W  = 23;
    localparam int SUM_W  = 25;
    localparam int PROD_W = 42;

    // Q16 weights of the RGB to LMS matrix, one row per cone response.
    localparam logic [15:0] MIX_Q16 [3][3] = '{
        '{16'd24976, 16'd37899, 16'd2635},
        '{16'd12891, 16'd47474, 16'd5125},
        '{16'd1579,  16'd8441,  16'd55339}
    };

    // log2(1 + k/16) in Q16 for k = 0 .. 16.
    localparam logic [LOG_W-1:0] LOG2_TAB [17] = '{
        17'd0,     17'd5732,  17'd11136, 17'd16248, 17'd21098, 17'd25711,
        17'd30109, 17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472,
        17'd52911, 17'd56229, 17'd59434, 17'd62534, 17'd65536
    };

    // log2(65536 * 255) in Q16: the log of a full-scale response.
    localparam logic signed [REL_W-1:0] LOG2_FULL_SCALE = 23'sd1572494;

    // Response used in place of an exact zero: 1/255 of full scale.
    localparam logic [RESP_W-1:0] RESP_FLOOR = 24'h010000;

    // ln2/sqrt3, ln2/sqrt6 and ln2/sqrt2 in Q16.
    localparam logic [15:0] K_LIGHT = 16'd26227;
    localparam logic [15:0] K_ALPHA = 16'd18545;
    localparam logic [15:0] K_BETA  = 16'd32121;

endpackage

>>> rtl/rgb_to_log_lalphabeta.sv
// ============================================================================
// rgb_to_log_lalphabeta: RGB pixel to logarithmic l-alpha-beta color
// Eight-stage pipeline: cone matrix, log2 by leading one and table, then
// decorrelation, rounding and saturation.
// ============================================================================
// The block takes one pixel per clock while the output side keeps tready
// high, and returns one result per pixel, in order. Each of the eight
// register stages holds its own valid bit and advances whenever the stage
// after it is free, so a stall on the output only holds back as many stages
// as are full, and bubbles are squeezed out.
// The deepest paths are the 13x19 interpolation multiply of the log table
// and the 25x17 multiply by the decorrelation weight, each in a stage alone.
// Black (all codes zero) is taken as a cone response of 1/255.
module rgb_to_log_lalphabeta #(
    parameter int FRAC_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [7:0] red, [15:8] green, [23:16] blue
    input  logic [rla_pkg::IN_DATA_W-1:0]  i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [16:0] lightness, [32:17] alpha_chroma, [48:33] beta_chroma, [55:49] zero
    output logic [rla_pkg::OUT_DATA_W-1:0] o_m_tdata
);

    localparam int SHIFT  = 32 - FRAC_BITS;
    localparam int NSTAGE = 8;
    localparam int RND_W  = rla_pkg::PROD_W + 1;

    localparam logic signed [RND_W-1:0] ROUND_HALF = RND_W'(64'sd1 <<< (SHIFT - 1));
    localparam logic signed [RND_W-1:0] LIGHT_MIN  = -RND_W'(65536);
    localparam logic signed [RND_W-1:0] LIGHT_MAX  = RND_W'(0);
    localparam logic signed [RND_W-1:0] CHROMA_MIN = -RND_W'(32768);
    localparam logic signed [RND_W-1:0] CHROMA_MAX = RND_W'(32767);

    // Stage valid bits and per-stage ready.
    logic [NSTAGE:1] r_vld;
    logic [NSTAGE:1] w_rdy;

    // Stage 1: matrix products.
    logic [rla_pkg::RESP_W-1:0] r_prd  [3][3];
    // Stage 2: cone responses.
    logic [rla_pkg::RESP_W-1:0] r_resp [3];
    // Stage 3: leading-one position and normalized mantissa.
    logic [rla_pkg::EXP_W-1:0]  r_exp3 [3];
    logic [rla_pkg::MANT_W-1:0] r_mant [3];
    // Stage 4: table base and interpolation step.
    logic [rla_pkg::EXP_W-1:0]  r_exp4 [3];
    logic [rla_pkg::LOG_W-1:0]  r_base [3];
    logic [rla_pkg::DIFF_W-1:0] r_step [3];
    // Stage 5: log2 relative to full scale.
    logic signed [rla_pkg::REL_W-1:0] r_rel [3];
    // Stage 6: channel combinations.
    logic signed [rla_pkg::SUM_W-1:0] r_sum_l, r_sum_a, r_sum_b;
    // Stage 7: weighted combinations.
    logic signed [rla_pkg::PROD_W-1:0] r_wt_l, r_wt_a, r_wt_b;
    // Stage 8: output fields.
    logic signed [rla_pkg::LIGHT_W-1:0]  r_light;
    logic signed [rla_pkg::CHROMA_W-1:0] r_alpha, r_beta;

    logic [rla_pkg::CODE_W-1:0]  w_code [3];
    logic [rla_pkg::RESP_W-1:0]  n_resp [3];
    logic [rla_pkg::EXP_W-1:0]   n_exp  [3];
    logic [rla_pkg::MANT_W-1:0]  n_mant [3];
    logic [rla_pkg::LOG_W-1:0]   n_base [3];
    logic [rla_pkg::DIFF_W-1:0]  n_step [3];
    logic signed [rla_pkg::REL_W-1:0] n_rel [3];
    logic signed [rla_pkg::LIGHT_W-1:0]  n_light;
    logic signed [rla_pkg::CHROMA_W-1:0] n_alpha, n_beta;

    // A stage takes new data when it is empty or its content moves on.
    always_comb begin
        w_rdy[NSTAGE] = !r_vld[NSTAGE] || i_m_tready;
        for (int k = NSTAGE - 1; k >= 1; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign o_s_tready = w_rdy[1];

    // Valid bits move with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[1]) begin
                r_vld[1] <= i_s_tvalid;
            end
            for (int k = 2; k <= NSTAGE; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign w_code[0] = i_s_tdata[7:0];
    assign w_code[1] = i_s_tdata[15:8];
    assign w_code[2] = i_s_tdata[23:16];

    // Cone response sums; black gets the floor response.
    always_comb begin
        logic [rla_pkg::RESP_W+1:0] acc;
        for (int c = 0; c < 3; c++) begin
            acc = {2'b00, r_prd[c][0]} + {2'b00, r_prd[c][1]} + {2'b00, r_prd[c][2]};
            n_resp[c] = acc[rla_pkg::RESP_W-1:0];
            if (n_resp[c] == '0) begin
                n_resp[c] = rla_pkg::RESP_FLOOR;
            end
        end
    end

    // Leading-one search and normalization of each response.
    always_comb begin
        logic [rla_pkg::RESP_W-1:0] shifted;
        for (int c = 0; c < 3; c++) begin
            n_exp[c] = '0;
            for (int i = 0; i < rla_pkg::RESP_W; i++) begin
                if (r_resp[c][i]) begin
                    n_exp[c] = rla_pkg::EXP_W'(i);
                end
            end
            shifted   = r_resp[c] << (5'd23 - n_exp[c]);
            n_mant[c] = shifted[rla_pkg::MANT_W-1:0];
        end
    end

    // Table lookup on the top four mantissa bits, linear step on the rest.
    always_comb begin
        logic [3:0]                 idx;
        logic [4:0]                 idx_nxt;
        logic [rla_pkg::DIFF_W-1:0] diff;
        logic [31:0]                prod;
        logic [rla_pkg::LOG_W-1:0]  upper;
        for (int c = 0; c < 3; c++) begin
            idx       = r_mant[c][22:19];
            idx_nxt   = {1'b0, idx} + 5'd1;
            n_base[c] = rla_pkg::LOG2_TAB[idx];
            upper     = rla_pkg::LOG2_TAB[idx_nxt];
            diff      = rla_pkg::DIFF_W'(upper - n_base[c]);
            prod      = 32'(diff) * 32'(r_mant[c][18:0]);
            n_step[c] = prod[31:19];
        end
    end

    // Integer part plus interpolated fraction, less the full-scale log.
    always_comb begin
        logic [rla_pkg::REL_W-2:0] whole;
        for (int c = 0; c < 3; c++) begin
            whole = {1'b0, r_exp4[c], 16'b0} + (rla_pkg::REL_W-1)'(r_base[c])
                    + (rla_pkg::REL_W-1)'(r_step[c]);
            n_rel[c] = $signed({1'b0, whole}) - rla_pkg::LOG2_FULL_SCALE;
        end
    end

    // Rounding to nearest (ties up) and saturation of the three channels.
    always_comb begin
        logic signed [RND_W-1:0] rl, ra, rb;
        rl = ($signed({r_wt_l[rla_pkg::PROD_W-1], r_wt_l}) + ROUND_HALF) >>> SHIFT;
        ra = ($signed({r_wt_a[rla_pkg::PROD_W-1], r_wt_a}) + ROUND_HALF) >>> SHIFT;
        rb = ($signed({r_wt_b[rla_pkg::PROD_W-1], r_wt_b}) + ROUND_HALF) >>> SHIFT;
        if (rl < LIGHT_MIN) begin
            rl = LIGHT_MIN;
        end else if (rl > LIGHT_MAX) begin
            rl = LIGHT_MAX;
        end
        if (ra < CHROMA_MIN) begin
            ra = CHROMA_MIN;
        end else if (ra > CHROMA_MAX) begin
            ra = CHROMA_MAX;
        end
        if (rb < CHROMA_MIN) begin
            rb = CHROMA_MIN;
        end else if (rb > CHROMA_MAX) begin
            rb = CHROMA_MAX;
        end
        n_light = rl[rla_pkg::LIGHT_W-1:0];
        n_alpha = ra[rla_pkg::CHROMA_W-1:0];
        n_beta  = rb[rla_pkg::CHROMA_W-1:0];
    end

    // Pipeline payload registers.
    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            for (int c = 0; c < 3; c++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prd[c][j] <= rla_pkg::RESP_W'(rla_pkg::MIX_Q16[c][j])
                                   * rla_pkg::RESP_W'(w_code[j]);
                end
            end
        end
        if (w_rdy[2]) begin
            r_resp <= n_resp;
        end
        if (w_rdy[3]) begin
            r_exp3 <= n_exp;
            r_mant <= n_mant;
        end
        if (w_rdy[4]) begin
            r_exp4 <= r_exp3;
            r_base <= n_base;
            r_step <= n_step;
        end
        if (w_rdy[5]) begin
            r_rel <= n_rel;
        end
        if (w_rdy[6]) begin
            r_sum_l <= rla_pkg::SUM_W'(r_rel[0]) + rla_pkg::SUM_W'(r_rel[1])
                       + rla_pkg::SUM_W'(r_rel[2]);
            r_sum_a <= rla_pkg::SUM_W'(r_rel[0]) + rla_pkg::SUM_W'(r_rel[1])
                       - (rla_pkg::SUM_W'(r_rel[2]) <<< 1);
            r_sum_b <= rla_pkg::SUM_W'(r_rel[0]) - rla_pkg::SUM_W'(r_rel[1]);
        end
        if (w_rdy[7]) begin
            r_wt_l <= rla_pkg::PROD_W'(r_sum_l)
                      * rla_pkg::PROD_W'($signed({1'b0, rla_pkg::K_LIGHT}));
            r_wt_a <= rla_pkg::PROD_W'(r_sum_a)
                      * rla_pkg::PROD_W'($signed({1'b0, rla_pkg::K_ALPHA}));
            r_wt_b <= rla_pkg::PROD_W'(r_sum_b)
                      * rla_pkg::PROD_W'($signed({1'b0, rla_pkg::K_BETA}));
        end
        if (w_rdy[8]) begin
            r_light <= n_light;
            r_alpha <= n_alpha;
            r_beta  <= n_beta;
        end
    end

    assign o_m_tvalid = r_vld[NSTAGE];
    assign o_m_tdata  = {7'b0, r_beta, r_alpha, r_light};

endmodule

>>> rtl/rla_checker.sv
// ============================================================================
// rla_checker: port-level checks for the l-alpha-beta converter
// Watches the stream ports and is bound to the top level.
// ============================================================================
module rla_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [23:0] i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [55:0] o_m_tdata
);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result shown right after reset");

    // A result that is not taken stays as it is.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // With nothing waiting at the output, every stage is free for a request.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with an empty output");

    // Lightness never exceeds zero and the pad bits stay clear.
    a_light_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[16] || o_m_tdata[15:0] == 16'd0)
                       && o_m_tdata[55:49] == 7'd0)
        else $error("lightness out of range or pad bits set");

endmodule

bind rgb_to_log_lalphabeta rla_checker u_rla_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
